// ----- hw/rtl/wve_pkg.sv -----
// ----------------------------------------------------------------------------
// wve_pkg
// Shared types and constants of the windowed velocity estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package wve_pkg;

  localparam int unsigned DATA_W = 32;
  // divider: magnitude of the dividend, signed dividend, signed divisor
  localparam int unsigned DIV_N_W = 50;
  localparam int unsigned DIV_Q_W = 51;
  localparam int unsigned DIV_D_W = 34;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  typedef enum logic [2:0] {
    OP_VEL_1     = 3'd0,
    OP_VEL_SHORT = 3'd1,
    OP_VEL_LONG  = 3'd2,
    OP_RAD_SHORT = 3'd3,
    OP_RAD_LONG  = 3'd4,
    OP_TIME_LONG = 3'd5
  } op_e;

  typedef struct packed {
    logic                       start;
    logic signed [DIV_Q_W-1:0]  dividend;
    logic signed [DIV_D_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [DIV_Q_W-1:0]  quotient;
  } div_rsp_t;

  // final velocity: {flag, value}
  function automatic logic [DATA_W:0] vel_fin(input logic signed [DATA_W:0] dl,
                                              input logic signed [DATA_W:0] dt,
                                              input logic signed [DIV_Q_W-1:0] q);
    logic [DATA_W:0] res;
    res = '0;
    if (dt == '0) begin
      res[DATA_W] = 1'b1;
      if (dl > 0) begin
        res[DATA_W-1:0] = 32'h7FFF_FFFF;
      end else if (dl < 0) begin
        res[DATA_W-1:0] = 32'h8000_0000;
      end
    end else if (q > 51'sd2147483647) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (q < -51'sd2147483648) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, q[DATA_W-1:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wve_div.sv -----
// ----------------------------------------------------------------------------
// wve_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module wve_div (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wve_pkg::div_req_t  req_i,
  output wve_pkg::div_rsp_t  rsp_o
);

  localparam int unsigned NW = wve_pkg::DIV_N_W;
  localparam int unsigned QW = wve_pkg::DIV_Q_W;
  localparam int unsigned DW = wve_pkg::DIV_D_W;
  localparam int unsigned CW = $clog2(NW + 1);

  logic          run_q, done_q, neg_q;
  logic [NW-1:0] a_q;
  logic [DW-2:0] d_q, rem_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] trial, diff;
  logic [QW-1:0] num_abs;
  logic [DW-1:0] den_abs;

  assign num_abs = req_i.dividend[QW-1] ? QW'(-req_i.dividend) : QW'(req_i.dividend);
  assign den_abs = req_i.divisor[DW-1] ? DW'(-req_i.divisor) : DW'(req_i.divisor);
  assign trial   = {rem_q, a_q[NW-1]};
  assign diff    = trial - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      a_q    <= '0;
      d_q    <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        neg_q <= req_i.dividend[QW-1] ^ req_i.divisor[DW-1];
        a_q   <= num_abs[NW-1:0];
        d_q   <= den_abs[DW-2:0];
        rem_q <= '0;
        cnt_q <= CW'(NW);
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= diff[DW-1] ? trial[DW-2:0] : diff[DW-2:0];
        a_q   <= {a_q[NW-2:0], ~diff[DW-1]};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -$signed({1'b0, a_q}) : $signed({1'b0, a_q});

  ap_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !run_q)
    else $error("divider started while busy");
  ap_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held");
  ap_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q))
    else $error("divider done without run");

endmodule

`default_nettype wire

// ----- hw/rtl/windowed_velocity_estimator.sv -----
// ----------------------------------------------------------------------------
// windowed_velocity_estimator
// Velocity and window means over a history of committed tip samples.
// ----------------------------------------------------------------------------
// Input channel s_axis: one request per sample (time, location, radius).
// The first sample primes the block and gives no result. A later sample
// whose time is above the reference time commits the pending sample into a
// ring memory and gives one result on m_axis; any other sample only
// replaces the pending sample and is done in its accept cycle.
// A commit takes 3 memory reads (lag 1, short and long entries, registered
// read data), one sum update and six divisions on one shared 50-step
// bit-serial divider. s_axis_tready is high only while no commit is in work.
// A finished result sits in the output register; the next sample is taken
// while it waits, and a further commit stalls at its last step until the
// receiver takes the held result. The history memory needs no clearing:
// only entries below the commit count are ever used.
// Reset empties the history count, unprimes the block, drops the output.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_velocity_estimator #(
  parameter int unsigned HISTORY_DEPTH = 201,
  parameter int unsigned SHORT_SPAN    = 10,
  parameter int unsigned LONG_SPAN     = 200
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // sample_time, sample_loc, sample_rad
  input  wire  [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // committed_time, committed_loc, committed_rad, step_dt, vel_lag1,
  // vel_lag10, vel_lag200, rad_mean_short, rad_mean_long, time_mean_long
  output logic [319:0] m_axis_tdata,
  // vel_saturated
  output logic [0:0]   m_axis_tuser
);

  localparam int unsigned PTR_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SS_W  = 33 + $clog2(SHORT_SPAN);
  localparam int unsigned SL_W  = 33 + $clog2(LONG_SPAN);
  localparam int unsigned QW    = wve_pkg::DIV_Q_W;
  localparam int unsigned DW    = wve_pkg::DIV_D_W;
  localparam int unsigned OFF_1 = HISTORY_DEPTH - 2;
  localparam int unsigned OFF_S = (2 * HISTORY_DEPTH - 1 - (SHORT_SPAN % HISTORY_DEPTH))
                                  % HISTORY_DEPTH;
  localparam int unsigned OFF_L = (2 * HISTORY_DEPTH - 1 - (LONG_SPAN % HISTORY_DEPTH))
                                  % HISTORY_DEPTH;

  wve_pkg::state_e state_q;
  wve_pkg::op_e    op_q;

  logic               primed_q;
  logic signed [31:0] seed_q, pend_loc_q, pend_rad_q, ref_q;
  logic [PTR_W-1:0]   wp_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [1:0]         rd_idx_q;
  logic               div_run_q;

  logic signed [31:0] e0_t_q, e0_l_q, e0_r_q;
  logic signed [31:0] e1_t_q, e1_l_q;
  logic signed [31:0] es_t_q, es_l_q, es_r_q;
  logic signed [31:0] el_t_q, el_l_q, el_r_q;
  logic signed [SS_W-1:0] sum_s_q;
  logic signed [SL_W-1:0] sum_lr_q, sum_lt_q;
  logic signed [QW-1:0]   q_v1_q, q_vs_q, q_vl_q, q_rs_q, q_rl_q, q_tl_q;

  logic               m_valid_q, m_user_q;
  logic [319:0]       m_data_q;

  // history ring: {rad, loc, time}
  logic [95:0]        hist_mem [HISTORY_DEPTH];
  logic [95:0]        rd_data_q;
  logic               wr_en, rd_en;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W:0]     slot_sum;
  logic [PTR_W:0]     rd_off;

  logic signed [31:0] in_t, in_l, in_r;
  logic               in_acc, commit;
  logic               ent_valid;

  logic signed [32:0] dl1, dt1, dls, dts, dll, dtl, dl_sel, dt_sel;
  logic [CNT_W:0]     n_s, n_l;
  wve_pkg::div_req_t  div_req;
  wve_pkg::div_rsp_t  div_rsp;
  logic [32:0]        f1, fs, fl;
  logic signed [31:0] dt_out;

  assign in_t   = s_axis_tdata[31:0];
  assign in_l   = s_axis_tdata[63:32];
  assign in_r   = s_axis_tdata[95:64];
  assign s_axis_tready = (state_q == wve_pkg::ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign commit = primed_q && (in_t > ref_q);
  assign wr_en  = in_acc && commit;
  assign rd_en  = (state_q == wve_pkg::ST_READ) && (rd_idx_q != 2'd3);

  always_comb begin
    case (rd_idx_q)
      2'd0:    rd_off = (PTR_W+1)'(OFF_1);
      2'd1:    rd_off = (PTR_W+1)'(OFF_S);
      default: rd_off = (PTR_W+1)'(OFF_L);
    endcase
    slot_sum = {1'b0, wp_q} + rd_off;
    if (slot_sum >= (PTR_W+1)'(HISTORY_DEPTH)) begin
      slot_sum = slot_sum - (PTR_W+1)'(HISTORY_DEPTH);
    end
    rd_addr = slot_sum[PTR_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wp_q] <= {pend_rad_q, pend_loc_q, ref_q};
    end
    if (rd_en) begin
      rd_data_q <= hist_mem[rd_addr];
    end
  end

  // entry captured this cycle was read in the previous one
  always_comb begin
    case (rd_idx_q)
      2'd1:    ent_valid = 32'(cnt_q) > 1;
      2'd2:    ent_valid = 32'(cnt_q) > SHORT_SPAN;
      default: ent_valid = 32'(cnt_q) > LONG_SPAN;
    endcase
  end

  assign dl1 = 33'(e0_l_q) - 33'(e1_l_q);
  assign dt1 = 33'(e0_t_q) - 33'(e1_t_q);
  assign dls = 33'(e0_l_q) - 33'(es_l_q);
  assign dts = 33'(e0_t_q) - 33'(es_t_q);
  assign dll = 33'(e0_l_q) - 33'(el_l_q);
  assign dtl = 33'(e0_t_q) - 33'(el_t_q);
  assign n_s = (32'(cnt_q) > SHORT_SPAN) ? (CNT_W+1)'(SHORT_SPAN) : (CNT_W+1)'(cnt_q);
  assign n_l = (32'(cnt_q) > LONG_SPAN) ? (CNT_W+1)'(LONG_SPAN) : (CNT_W+1)'(cnt_q);

  always_comb begin
    dl_sel = dl1;
    dt_sel = dt1;
    div_req.start    = (state_q == wve_pkg::ST_DIV) && !div_run_q;
    div_req.dividend = '0;
    div_req.divisor  = DW'(1);
    case (op_q)
      wve_pkg::OP_VEL_1: begin
        dl_sel = dl1;
        dt_sel = dt1;
      end
      wve_pkg::OP_VEL_SHORT: begin
        dl_sel = dls;
        dt_sel = dts;
      end
      default: begin
        dl_sel = dll;
        dt_sel = dtl;
      end
    endcase
    case (op_q)
      wve_pkg::OP_RAD_SHORT: begin
        div_req.dividend = QW'(sum_s_q);
        div_req.divisor  = $signed({1'b0, (DW-1)'(n_s)});
      end
      wve_pkg::OP_RAD_LONG: begin
        div_req.dividend = QW'(sum_lr_q);
        div_req.divisor  = $signed({1'b0, (DW-1)'(n_l)});
      end
      wve_pkg::OP_TIME_LONG: begin
        div_req.dividend = QW'(sum_lt_q);
        div_req.divisor  = $signed({1'b0, (DW-1)'(n_l)});
      end
      default: begin
        // zero dt is resolved after the divide
        div_req.dividend = QW'(dl_sel) <<< 16;
        div_req.divisor  = (dt_sel == '0) ? DW'(1) : DW'(dt_sel);
      end
    endcase
  end

  wve_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign f1 = wve_pkg::vel_fin(dl1, dt1, q_v1_q);
  assign fs = wve_pkg::vel_fin(dls, dts, q_vs_q);
  assign fl = wve_pkg::vel_fin(dll, dtl, q_vl_q);
  assign dt_out = (dt1 > 33'sd2147483647) ? 32'sh7FFF_FFFF :
                  (dt1 < -33'sd2147483648) ? 32'sh8000_0000 : dt1[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wve_pkg::ST_IDLE;
      op_q       <= wve_pkg::OP_VEL_1;
      primed_q   <= 1'b0;
      seed_q     <= '0;
      pend_loc_q <= '0;
      pend_rad_q <= '0;
      ref_q      <= '0;
      wp_q       <= '0;
      cnt_q      <= '0;
      rd_idx_q   <= '0;
      div_run_q  <= 1'b0;
      sum_s_q    <= '0;
      sum_lr_q   <= '0;
      sum_lt_q   <= '0;
      m_valid_q  <= 1'b0;
      m_user_q   <= 1'b0;
      m_data_q   <= '0;
      e0_t_q <= '0; e0_l_q <= '0; e0_r_q <= '0;
      e1_t_q <= '0; e1_l_q <= '0;
      es_t_q <= '0; es_l_q <= '0; es_r_q <= '0;
      el_t_q <= '0; el_l_q <= '0; el_r_q <= '0;
      q_v1_q <= '0; q_vs_q <= '0; q_vl_q <= '0;
      q_rs_q <= '0; q_rl_q <= '0; q_tl_q <= '0;
    end else begin
      if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        wve_pkg::ST_IDLE: begin
          if (in_acc) begin
            pend_loc_q <= in_l;
            pend_rad_q <= in_r;
            if (!primed_q) begin
              primed_q <= 1'b1;
              seed_q   <= in_l;
              ref_q    <= in_t;
            end else if (commit) begin
              e0_t_q   <= ref_q;
              e0_l_q   <= pend_loc_q;
              e0_r_q   <= pend_rad_q;
              ref_q    <= in_t;
              wp_q     <= (wp_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
              if (cnt_q != CNT_W'(HISTORY_DEPTH)) begin
                cnt_q <= cnt_q + 1'b1;
              end
              rd_idx_q <= '0;
              state_q  <= wve_pkg::ST_READ;
            end
          end
        end
        wve_pkg::ST_READ: begin
          rd_idx_q <= rd_idx_q + 1'b1;
          case (rd_idx_q)
            2'd1: begin
              e1_t_q <= ent_valid ? rd_data_q[31:0]  : '0;
              e1_l_q <= ent_valid ? rd_data_q[63:32] : seed_q;
            end
            2'd2: begin
              es_t_q <= ent_valid ? rd_data_q[31:0]  : '0;
              es_l_q <= ent_valid ? rd_data_q[63:32] : seed_q;
              es_r_q <= ent_valid ? rd_data_q[95:64] : '0;
            end
            2'd3: begin
              el_t_q  <= ent_valid ? rd_data_q[31:0]  : '0;
              el_l_q  <= ent_valid ? rd_data_q[63:32] : seed_q;
              el_r_q  <= ent_valid ? rd_data_q[95:64] : '0;
              state_q <= wve_pkg::ST_SUM;
            end
            default: begin
            end
          endcase
        end
        wve_pkg::ST_SUM: begin
          // running sums: add the new entry, drop the one leaving the window
          sum_s_q  <= sum_s_q + SS_W'(e0_r_q) - SS_W'(es_r_q);
          sum_lr_q <= sum_lr_q + SL_W'(e0_r_q) - SL_W'(el_r_q);
          sum_lt_q <= sum_lt_q + SL_W'(e0_t_q) - SL_W'(el_t_q);
          op_q     <= wve_pkg::OP_VEL_1;
          state_q  <= wve_pkg::ST_DIV;
        end
        wve_pkg::ST_DIV: begin
          if (div_req.start) begin
            div_run_q <= 1'b1;
          end else if (div_rsp.done) begin
            div_run_q <= 1'b0;
            case (op_q)
              wve_pkg::OP_VEL_1:     q_v1_q <= div_rsp.quotient;
              wve_pkg::OP_VEL_SHORT: q_vs_q <= div_rsp.quotient;
              wve_pkg::OP_VEL_LONG:  q_vl_q <= div_rsp.quotient;
              wve_pkg::OP_RAD_SHORT: q_rs_q <= div_rsp.quotient;
              wve_pkg::OP_RAD_LONG:  q_rl_q <= div_rsp.quotient;
              default:               q_tl_q <= div_rsp.quotient;
            endcase
            if (op_q == wve_pkg::OP_TIME_LONG) begin
              state_q <= wve_pkg::ST_FIN;
            end else begin
              op_q <= wve_pkg::op_e'(op_q + 3'd1);
            end
          end
        end
        wve_pkg::ST_FIN: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            if (cnt_q == CNT_W'(1)) begin
              m_user_q <= 1'b0;
              m_data_q <= {q_tl_q[31:0], q_rl_q[31:0], q_rs_q[31:0], 96'd0,
                           dt_out, e0_r_q, e0_l_q, e0_t_q};
            end else begin
              m_user_q <= f1[32] | fs[32] | fl[32];
              m_data_q <= {q_tl_q[31:0], q_rl_q[31:0], q_rs_q[31:0], fl[31:0],
                           fs[31:0], f1[31:0], dt_out, e0_r_q, e0_l_q, e0_t_q};
            end
            state_q <= wve_pkg::ST_IDLE;
          end
        end
        default: begin
          state_q <= wve_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  ap_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(HISTORY_DEPTH))
    else $error("commit count above depth");
  ap_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q < PTR_W'(HISTORY_DEPTH))
    else $error("write pointer out of range");
  ap_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == wve_pkg::ST_FIN))
    else $error("result raised outside final step");
  ap_write_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> state_q == wve_pkg::ST_READ)
    else $error("history write without commit sequence");

endmodule

`default_nettype wire

// ----- tb/tb_windowed_velocity_estimator.sv -----
// ----------------------------------------------------------------------------
// tb_windowed_velocity_estimator
// Self-checking testbench for the windowed velocity estimator.
// Drives timestamped samples with random gaps, predicts each commit result
// from its own copy of the history and compares every output field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_windowed_velocity_estimator;

  localparam int DEPTH  = 201;
  localparam int SHORTW = 10;
  localparam int LONGW  = 200;
  localparam int IDLE_LIMIT = 20000;
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] c_time;
    logic signed [31:0] c_loc;
    logic signed [31:0] c_rad;
    logic signed [31:0] dt;
    logic signed [31:0] v1;
    logic signed [31:0] v10;
    logic signed [31:0] v200;
    logic signed [31:0] rmean_s;
    logic signed [31:0] rmean_l;
    logic signed [31:0] tmean_l;
    logic               sat;
  } commit_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [319:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  windowed_velocity_estimator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // predictor state
  longint h_time [DEPTH];
  longint h_loc  [DEPTH];
  longint h_rad  [DEPTH];
  int     wr_ptr;
  int     n_commits;
  bit     is_primed;
  longint seed;
  longint pend_loc;
  longint pend_rad;
  longint ref_time;

  commit_t expected_commits[$];
  int      n_fail = 0;
  int      idle_cycles = 0;
  bit      stall_heavy;

  function automatic void hist_entry(input int k, output longint t, output longint l,
                                     output longint r);
    int slot;
    if (k < n_commits && k < DEPTH) begin
      slot = (wr_ptr + 2 * DEPTH - 1 - k) % DEPTH;
      t = h_time[slot];
      l = h_loc[slot];
      r = h_rad[slot];
    end else begin
      t = 0;
      l = seed;
      r = 0;
    end
  endfunction

  function automatic longint lag_velocity(input int lag, inout bit sat);
    longint t0, l0, r0, tk, lk, rk, dl, dt, q;
    hist_entry(0, t0, l0, r0);
    hist_entry(lag, tk, lk, rk);
    dl = l0 - lk;
    dt = t0 - tk;
    if (dt == 0) begin
      sat = 1'b1;
      return (dl > 0) ? MAXV : ((dl < 0) ? MINV : 0);
    end
    q = (dl * 65536) / dt;
    if (q > MAXV) begin
      sat = 1'b1;
      return MAXV;
    end
    if (q < MINV) begin
      sat = 1'b1;
      return MINV;
    end
    return q;
  endfunction

  function automatic longint window_avg(input int span, input bit of_time);
    int n;
    longint s, t, l, r;
    n = (span < n_commits) ? span : n_commits;
    s = 0;
    for (int k = 0; k < n; k++) begin
      hist_entry(k, t, l, r);
      s += of_time ? t : r;
    end
    return (n == 0) ? 0 : s / n;
  endfunction

  // update the history for one accepted sample, queue the commit if any
  function automatic void predict_commit(input logic signed [31:0] t,
                                         input logic signed [31:0] l,
                                         input logic signed [31:0] r);
    commit_t c;
    longint t0, t1, x, y, d;
    bit sat;
    if (!is_primed) begin
      is_primed = 1'b1;
      seed = l;
      ref_time = t;
      pend_loc = l;
      pend_rad = r;
      return;
    end
    if (longint'(t) > ref_time) begin
      h_time[wr_ptr] = ref_time;
      h_loc[wr_ptr] = pend_loc;
      h_rad[wr_ptr] = pend_rad;
      wr_ptr = (wr_ptr + 1) % DEPTH;
      if (n_commits < DEPTH) n_commits++;
      hist_entry(0, t0, x, y);
      hist_entry(1, t1, x, y);
      d = t0 - t1;
      if (d > MAXV) d = MAXV;
      if (d < MINV) d = MINV;
      sat = 1'b0;
      c.c_time = ref_time[31:0];
      c.c_loc = pend_loc[31:0];
      c.c_rad = pend_rad[31:0];
      c.dt = d[31:0];
      if (n_commits == 1) begin
        c.v1 = '0;
        c.v10 = '0;
        c.v200 = '0;
      end else begin
        c.v1 = 32'(lag_velocity(1, sat));
        c.v10 = 32'(lag_velocity(SHORTW, sat));
        c.v200 = 32'(lag_velocity(LONGW, sat));
      end
      c.rmean_s = 32'(window_avg(SHORTW, 1'b0));
      c.rmean_l = 32'(window_avg(LONGW, 1'b0));
      c.tmean_l = 32'(window_avg(LONGW, 1'b1));
      c.sat = sat;
      expected_commits.push_back(c);
      ref_time = t;
    end
    pend_loc = l;
    pend_rad = r;
  endfunction

  // mostly short gaps, a few long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  task automatic send_sample(input logic signed [31:0] t, input logic signed [31:0] l,
                             input logic signed [31:0] r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r, l, t};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_commit(t, l, r);
  endtask

  task automatic test_priming_and_unfilled();
    // prime at the lowest time, extreme location and radius
    send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    // not later than the reference: only replaces the pending sample
    send_sample(32'sh8000_0000, 32'sh0000_1000, 32'sh7FFF_FFFF);
    send_sample(32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    // entry 0 at time zero against unfilled entries: zero dt
    send_sample(32'sh0000_0001, 32'sh8000_0000, 32'sh0000_0000);
    send_sample(32'sh0000_0002, 32'sh0000_0000, 32'sh8000_0000);
    send_sample(32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0001_0000);
    send_sample(32'sh0000_0002, 32'sh1234_5678, 32'shFFFF_0000);
  endtask

  task automatic test_velocity_clipping();
    // tiny dt with full-range location swings
    send_sample(32'sh0000_0003, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_sample(32'sh0000_0004, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_sample(32'sh0000_0005, 32'sh8000_0000, 32'sh0000_0001);
    send_sample(32'sh0000_0006, 32'sh0000_0000, 32'shFFFF_FFFF);
    send_sample(32'sh0000_0006, 32'sh7FFF_FFFF, 32'sh0000_0000);
    send_sample(32'sh0000_0007, 32'sh0000_0000, 32'sh0000_0000);
    send_sample(32'sh0001_0007, 32'sh0000_0000, 32'sh0000_0000);
    send_sample(32'sh0001_0008, 32'sh0000_0000, 32'sh0000_0000);
  endtask

  task automatic test_random_track(input int n_items);
    longint t, cur_t, l, cur_l;
    int p;
    cur_t = ref_time;
    cur_l = 0;
    for (int i = 0; i < n_items; i++) begin
      p = $urandom_range(0, 99);
      if (p < 70) begin
        t = cur_t + $urandom_range(1, 1 << 18);
      end else if (p < 78) begin
        t = cur_t + $urandom_range(1, 1 << 24);
      end else if (p < 84) begin
        t = cur_t;
      end else begin
        t = cur_t - $urandom_range(1, 1 << 20);
      end
      // the last items climb to the top of the time range
      if (i == n_items - 2) t = MAXV - 5;
      if (i == n_items - 1) t = MAXV;
      if (t > MAXV) t = MAXV;
      if (t < MINV) t = MINV;
      if (t > cur_t) cur_t = t;
      p = $urandom_range(0, 9);
      if (p < 2) begin
        l = longint'($signed($urandom()));
      end else begin
        l = cur_l + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        if (l > MAXV || l < MINV) l = 0;
      end
      cur_l = l;
      send_sample(t[31:0], l[31:0], $urandom());
      if (i == n_items / 2) stall_heavy = 1'b1;
      if (i == n_items / 2 + 100) stall_heavy = 1'b0;
    end
  endtask

  // receiver backpressure, with a stretch of heavy stalls
  always @(posedge clk_i) begin
    int p;
    p = $urandom_range(0, 99);
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_heavy) begin
      m_axis_tready <= (p < 20);
    end else if (p < 3) begin
      m_axis_tready <= 1'b0;
    end else if (p < 15) begin
      m_axis_tready <= ~m_axis_tready;
    end else if (p < 70) begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    commit_t got, exp_c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
             m_axis_tdata[127:96], m_axis_tdata[159:128], m_axis_tdata[191:160],
             m_axis_tdata[223:192], m_axis_tdata[255:224], m_axis_tdata[287:256],
             m_axis_tdata[319:288], m_axis_tuser[0]};
      if (expected_commits.size() == 0) begin
        $error("unexpected result with committed_time %0d", got.c_time);
        n_fail++;
      end else begin
        exp_c = expected_commits.pop_front();
        if (got.c_time !== exp_c.c_time) begin
          $error("committed_time exp %0d got %0d", exp_c.c_time, got.c_time);
          n_fail++;
        end
        if (got.c_loc !== exp_c.c_loc) begin
          $error("committed_loc exp %0d got %0d", exp_c.c_loc, got.c_loc);
          n_fail++;
        end
        if (got.c_rad !== exp_c.c_rad) begin
          $error("committed_rad exp %0d got %0d", exp_c.c_rad, got.c_rad);
          n_fail++;
        end
        if (got.dt !== exp_c.dt) begin
          $error("step_dt exp %0d got %0d", exp_c.dt, got.dt);
          n_fail++;
        end
        if (got.v1 !== exp_c.v1) begin
          $error("vel_lag1 exp %0d got %0d", exp_c.v1, got.v1);
          n_fail++;
        end
        if (got.v10 !== exp_c.v10) begin
          $error("vel_lag10 exp %0d got %0d", exp_c.v10, got.v10);
          n_fail++;
        end
        if (got.v200 !== exp_c.v200) begin
          $error("vel_lag200 exp %0d got %0d", exp_c.v200, got.v200);
          n_fail++;
        end
        if (got.rmean_s !== exp_c.rmean_s) begin
          $error("rad_mean_short exp %0d got %0d", exp_c.rmean_s, got.rmean_s);
          n_fail++;
        end
        if (got.rmean_l !== exp_c.rmean_l) begin
          $error("rad_mean_long exp %0d got %0d", exp_c.rmean_l, got.rmean_l);
          n_fail++;
        end
        if (got.tmean_l !== exp_c.tmean_l) begin
          $error("time_mean_long exp %0d got %0d", exp_c.tmean_l, got.tmean_l);
          n_fail++;
        end
        if (got.sat !== exp_c.sat) begin
          $error("vel_saturated exp %0d got %0d", exp_c.sat, got.sat);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer on either channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_windowed_velocity_estimator: FAIL");
      $finish;
    end
  end

  initial begin
    int wait_cycles;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    rst_ni = 1'b0;
    stall_heavy = 1'b0;
    wr_ptr = 0;
    n_commits = 0;
    is_primed = 1'b0;
    seed = 0;
    pend_loc = 0;
    pend_rad = 0;
    ref_time = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_priming_and_unfilled();
    test_velocity_clipping();
    test_random_track(1535);
    s_axis_tvalid <= 1'b0;

    wait_cycles = 0;
    while (expected_commits.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (400) @(posedge clk_i);
    if (n_fail == 0 && expected_commits.size() == 0) begin
      $display("tb_windowed_velocity_estimator: PASS");
    end else begin
      $display("tb_windowed_velocity_estimator: FAIL");
    end
    $finish;
  end

endmodule
